>>> hw/rtl/odo_pkg.sv
// Shared types, constants and arithmetic helpers for the three-wheel odometry core.
package odo_pkg;

	typedef struct packed {
		logic signed [31:0] left_position;
		logic signed [31:0] right_position;
		logic signed [31:0] rear_position;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_heading;
	} pose_t;

	localparam int CFG_W = 24;

	typedef enum logic [1:0] {
		REG_TICK_SCALE   = 2'd0,
		REG_LEFT_OFFSET  = 2'd1,
		REG_RIGHT_OFFSET = 2'd2,
		REG_REAR_OFFSET  = 2'd3
	} reg_idx_t;

	localparam logic [CFG_W-1:0] TICK_SCALE_RST   = 24'd1218130;
	localparam logic [CFG_W-1:0] LEFT_OFFSET_RST  = 24'd344064;
	localparam logic [CFG_W-1:0] RIGHT_OFFSET_RST = 24'd271974;
	localparam logic [CFG_W-1:0] REAR_OFFSET_RST  = 24'd131072;

	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [63:0] INV_PI_Q63 = 64'h28BE60DB9391054A;

	localparam int MUL_W  = 35;
	localparam int PROD_W = 2 * MUL_W;
	localparam int WIDE_W = 96;

	localparam logic signed [WIDE_W-1:0] S32_MAX = 96'sd2147483647;
	localparam logic signed [WIDE_W-1:0] S32_MIN = -96'sd2147483648;

	typedef enum logic [4:0] {
		C_NOP, C_LOAD, C_ML, C_MR, C_MS, C_DIVA, C_AQ, C_STRAIGHT,
		C_B1A, C_B1H, C_B2, C_B3, C_KDIV, C_KQ,
		C_H1, C_H2, C_H3, C_H4, C_H5, C_H6, C_H7, C_H8,
		C_O1, C_O2, C_O3, C_O4, C_O5, C_O6, C_POST
	} cmd_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_ML, ST_MR, ST_MS, ST_DIVA, ST_WAITA, ST_AQ, ST_ACHK,
		ST_AB1, ST_AB2, ST_AB3, ST_AW, ST_KDIV, ST_KW, ST_KQ,
		ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8,
		ST_HB1, ST_HB2, ST_HB3, ST_HW,
		ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_O6, ST_POST
	} state_t;

	typedef struct packed {
		logic span_zero;
		logic a_zero;
		logic div_busy;
		logic cordic_busy;
		logic out_busy;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX)
			r = 32'sh7FFFFFFF;
		else if (v < S32_MIN)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// add half an LSB, then floor
	function automatic logic signed [WIDE_W-1:0] rnd_shift(input logic signed [WIDE_W-1:0] v,
			input int s);
		logic signed [WIDE_W-1:0] half;
		half = 96'sd1 <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	// arctangent of 2^-i in binary-angle units
	function automatic logic [31:0] atan_bam(input logic [CORDIC_IW-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/three_wheel_odometry_core.sv
// Top level of the three-tracking-wheel arc odometry core.
// Each accepted sample of three absolute encoder positions produces one pose item
// (x, y in Q16.16 inches, heading in radians with ANGLE_FRAC_BITS fraction bits,
// all saturating). The time from acceptance to its pose item depends on whether
// the heading changes and whether the wheel spacing is zero, and it grows while
// the previous pose item still waits to be taken; the next sample can be accepted
// in the same cycle that the pose item appears. The work is done by the shared
// 64-step divider (heading change, then chord factor) and the 30-step CORDIC
// (half-angle, then mid-arc heading); one sample is in work at a time, and a new
// sample is taken while the previous pose item still waits in the output register.
// The user must write the configuration registers only while no sample is in
// work; the block itself does not enforce this.
module three_wheel_odometry_core #(
	parameter int ANGLE_FRAC_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  odo_pkg::reg_idx_t cfg_index,
	input  logic [23:0]       cfg_data,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  odo_pkg::sample_t  sample,
	output logic              pose_valid,
	input  logic              pose_ready,
	output odo_pkg::pose_t    pose
);
	import odo_pkg::*;

	cmd_t    cmd;
	status_t status;

	odo_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.status      (status),
		.cmd         (cmd)
	);

	odo_dp #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.pose_valid(pose_valid),
		.pose_ready(pose_ready),
		.pose      (pose)
	);
endmodule

>>> hw/rtl/odo_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module odo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        busy,
	output logic [63:0] quot
);
	localparam int NW = 64;
	localparam int CW = $clog2(NW);

	logic [NW-1:0] nq_q;
	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [32:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q, nq_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NW - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[NW-2:0], ge};
			rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
		end
	end

	assign busy = busy_q;
	assign quot = nq_q;
endmodule

>>> hw/rtl/odo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module odo_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               busy,
	output logic signed [32:0] cos_v,
	output logic signed [32:0] sin_v
);
	import odo_pkg::*;

	logic signed [32:0]    x_q, y_q, sx, sy;
	logic signed [33:0]    z_q, atan_v;
	logic [CORDIC_IW-1:0]  i_q;
	logic                  busy_q, flip_q;
	logic [31:0]           folded;
	logic                  flip;

	// fold into +-90 degrees by a half turn
	assign flip   = (angle + 32'h40000000) >= 32'h80000000;
	assign folded = flip ? angle + 32'h80000000 : angle;
	assign sx     = x_q >>> i_q;
	assign sy     = y_q >>> i_q;
	assign atan_v = 34'(atan_bam(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == CORDIC_IW'(CORDIC_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= 34'(signed'(folded));
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + atan_v;
			end
		end
	end

	assign busy  = busy_q;
	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;
endmodule

>>> hw/rtl/odo_dp.sv
// Odometry datapath: pose state, shared multiplier, divider, CORDIC and output register.
module odo_dp #(
	parameter int ANGLE_FRAC_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  odo_pkg::cmd_t          cmd,
	output odo_pkg::status_t       status,
	input  logic                   cfg_wen,
	input  odo_pkg::reg_idx_t      cfg_index,
	input  logic [23:0]            cfg_data,
	input  odo_pkg::sample_t       sample,
	output logic                   pose_valid,
	input  logic                   pose_ready,
	output odo_pkg::pose_t         pose
);
	import odo_pkg::*;

	localparam int F = ANGLE_FRAC_BITS;
	localparam logic [63:0] INV    = (INV_PI_Q63 + (64'd1 << F)) >> (F + 1);
	localparam logic [31:0] INV_LO = INV[31:0];
	localparam logic [31:0] INV_HI = INV[63:32];

	logic [CFG_W-1:0]        tick_q, loff_q, roff_q, soff_q;
	logic signed [31:0]      last_l_q, last_r_q, last_s_q;
	logic signed [31:0]      acc_x_q, acc_y_q, acc_h_q;
	logic signed [32:0]      dl_q, dr_q, ds_q;
	logic signed [PROD_W-1:0] mul_q, prod;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [31:0]      dist_l_q, dist_r_q, dist_s_q, a_q, h_q, h2_q, u_q;
	logic [33:0]             mag_q, mag_new;
	logic signed [33:0]      ang;
	logic                    neg_q, a_neg_q, k_neg_q;
	logic [31:0]             bamlo_q, bam_sum, bam;
	logic signed [33:0]      two_s_q, two_s_new;
	logic [33:0]             two_s_abs;
	logic signed [63:0]      k_q;
	logic signed [31:0]      k_hi;
	logic signed [WIDE_W-1:0] t_q;
	logic [24:0]             span;
	logic signed [32:0]      lr_diff;
	logic [32:0]             lr_abs;
	logic [31:0]             a_abs;
	logic [63:0]             dnum, quot;
	logic [31:0]             dden;
	logic                    div_start, div_busy, cordic_busy;
	logic signed [32:0]      cos_v, sin_v;
	logic signed [31:0]      a_val;
	pose_t                   pose_q;
	logic                    pose_valid_q;

	assign span      = 25'(loff_q) + 25'(roff_q);
	assign lr_diff   = 33'(dist_l_q) - 33'(dist_r_q);
	assign lr_abs    = lr_diff[32] ? 33'(-lr_diff) : 33'(lr_diff);
	assign a_abs     = a_q[31] ? 32'(-a_q) : 32'(a_q);
	assign two_s_new = 34'(sin_v) <<< 1;
	assign two_s_abs = two_s_new[33] ? 34'(-two_s_new) : 34'(two_s_new);
	assign k_hi      = k_q[63:32];

	// angle to turn into a binary angle: a, or twice the heading plus a
	always_comb begin
		if (cmd == C_B1H)
			ang = (34'(acc_h_q) <<< 1) + 34'(a_q);
		else
			ang = 34'(a_q);
		mag_new = ang[33] ? 34'(-ang) : 34'(ang);
	end

	assign bam_sum = bamlo_q + mul_q[31:0];
	assign bam     = neg_q ? 32'(-bam_sum) : bam_sum;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd)
			C_ML:         begin ma = MUL_W'(dl_q);      mb = MUL_W'(tick_q);     end
			C_MR:         begin ma = MUL_W'(dr_q);      mb = MUL_W'(tick_q);     end
			C_MS:         begin ma = MUL_W'(ds_q);      mb = MUL_W'(tick_q);     end
			C_B1A, C_B1H: begin ma = MUL_W'(mag_new);   mb = MUL_W'(INV_LO);     end
			C_B2:         begin ma = MUL_W'(mag_q);     mb = MUL_W'(INV_HI);     end
			C_H1:         begin ma = MUL_W'(roff_q);    mb = MUL_W'(two_s_q);    end
			C_H2:         begin ma = MUL_W'(dist_r_q);  mb = MUL_W'(k_q[31:0]);  end
			C_H3:         begin ma = MUL_W'(dist_r_q);  mb = MUL_W'(k_hi);       end
			C_H4:         begin ma = MUL_W'(soff_q);    mb = MUL_W'(two_s_q);    end
			C_H5:         begin ma = MUL_W'(dist_s_q);  mb = MUL_W'(k_q[31:0]);  end
			C_H6:         begin ma = MUL_W'(dist_s_q);  mb = MUL_W'(k_hi);       end
			C_O1:         begin ma = MUL_W'(h_q);       mb = MUL_W'(sin_v);      end
			C_O2:         begin ma = MUL_W'(h2_q);      mb = MUL_W'(cos_v);      end
			C_O3:         begin ma = MUL_W'(h_q);       mb = MUL_W'(cos_v);      end
			C_O4:         begin ma = MUL_W'(h2_q);      mb = MUL_W'(sin_v);      end
			default:      begin ma = '0;                mb = '0;                 end
		endcase
	end

	assign prod = PROD_W'(ma) * PROD_W'(mb);

	always_comb begin
		case (cmd)
			C_KDIV: begin
				dnum = 64'(two_s_abs) << F;
				dden = a_abs;
			end
			default: begin
				dnum = 64'(lr_abs) << F;
				dden = 32'(span);
			end
		endcase
	end

	assign div_start = (cmd == C_DIVA && span != '0) || cmd == C_KDIV;

	odo_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (dnum),
		.den   (dden),
		.busy  (div_busy),
		.quot  (quot)
	);

	odo_cordic u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd == C_B3),
		.angle (bam),
		.busy  (cordic_busy),
		.cos_v (cos_v),
		.sin_v (sin_v)
	);

	// truncated quotient with sign, saturated to 32 bits
	always_comb begin
		if (!a_neg_q)
			a_val = (quot > 64'd2147483647) ? 32'sh7FFFFFFF : signed'(quot[31:0]);
		else
			a_val = (quot > 64'd2147483648) ? 32'sh80000000 : signed'(32'(-quot[31:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= TICK_SCALE_RST;
			loff_q       <= LEFT_OFFSET_RST;
			roff_q       <= RIGHT_OFFSET_RST;
			soff_q       <= REAR_OFFSET_RST;
			last_l_q     <= '0;
			last_r_q     <= '0;
			last_s_q     <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			acc_h_q      <= '0;
			pose_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_TICK_SCALE:   tick_q <= cfg_data;
					REG_LEFT_OFFSET:  loff_q <= cfg_data;
					REG_RIGHT_OFFSET: roff_q <= cfg_data;
					REG_REAR_OFFSET:  soff_q <= cfg_data;
					default:          tick_q <= tick_q;
				endcase
			end
			if (cmd == C_LOAD) begin
				last_l_q <= sample.left_position;
				last_r_q <= sample.right_position;
				last_s_q <= sample.rear_position;
			end
			if (cmd == C_O4)
				acc_x_q <= sat32(WIDE_W'(acc_x_q) + rnd_shift(t_q, 30));
			if (cmd == C_O6) begin
				acc_y_q <= sat32(WIDE_W'(acc_y_q) + rnd_shift(t_q, 30));
				acc_h_q <= sat32(WIDE_W'(acc_h_q) + WIDE_W'(a_q));
			end
			if (cmd == C_POST)
				pose_valid_q <= 1'b1;
			else if (pose_ready)
				pose_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= prod;
		case (cmd)
			C_LOAD: begin
				dl_q <= 33'(sample.left_position) - 33'(last_l_q);
				dr_q <= 33'(sample.right_position) - 33'(last_r_q);
				ds_q <= 33'(sample.rear_position) - 33'(last_s_q);
			end
			C_MR: dist_l_q <= sat32(rnd_shift(WIDE_W'(mul_q), 16));
			C_MS: dist_r_q <= sat32(rnd_shift(WIDE_W'(mul_q), 16));
			C_DIVA: begin
				dist_s_q <= sat32(rnd_shift(WIDE_W'(mul_q), 16));
				a_neg_q  <= lr_diff[32];
				a_q      <= '0;
			end
			C_AQ: a_q <= a_val;
			C_STRAIGHT: begin
				h_q  <= dist_r_q;
				h2_q <= dist_s_q;
			end
			C_B1A, C_B1H: begin
				mag_q <= mag_new;
				neg_q <= ang[33];
			end
			C_B2: bamlo_q <= mul_q[63:32];
			C_KDIV: begin
				two_s_q <= two_s_new;
				k_neg_q <= sin_v[32] ^ a_q[31];
			end
			C_KQ: k_q <= k_neg_q ? -signed'(quot) : signed'(quot);
			C_H2: u_q <= 32'(rnd_shift(WIDE_W'(mul_q), 30));
			C_H3: t_q <= WIDE_W'(mul_q);
			C_H4: t_q <= t_q + (WIDE_W'(mul_q) <<< 32);
			C_H5: begin
				h_q <= sat32(rnd_shift(t_q, 30) + WIDE_W'(u_q));
				u_q <= 32'(rnd_shift(WIDE_W'(mul_q), 30));
			end
			C_H6: t_q <= WIDE_W'(mul_q);
			C_H7: t_q <= t_q + (WIDE_W'(mul_q) <<< 32);
			C_H8: h2_q <= sat32(rnd_shift(t_q, 30) + WIDE_W'(u_q));
			C_O2: t_q <= WIDE_W'(mul_q);
			C_O3: t_q <= t_q + WIDE_W'(mul_q);
			C_O4: t_q <= WIDE_W'(mul_q);
			C_O5: t_q <= t_q - WIDE_W'(mul_q);
			C_POST: begin
				pose_q.pose_x       <= acc_x_q;
				pose_q.pose_y       <= acc_y_q;
				pose_q.pose_heading <= acc_h_q;
			end
			default: t_q <= t_q;
		endcase
	end

	assign status.span_zero   = span == '0;
	assign status.a_zero      = a_q == '0;
	assign status.div_busy    = div_busy;
	assign status.cordic_busy = cordic_busy;
	assign status.out_busy    = pose_valid_q && !pose_ready;

	assign pose_valid = pose_valid_q;
	assign pose       = pose_q;
endmodule

>>> hw/rtl/odo_ctrl.sv
// Odometry sequencer: steps the datapath through one sample.
module odo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  odo_pkg::status_t  status,
	output odo_pkg::cmd_t     cmd
);
	import odo_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (sample_valid) state_d = ST_ML;
			ST_ML:    state_d = ST_MR;
			ST_MR:    state_d = ST_MS;
			ST_MS:    state_d = ST_DIVA;
			ST_DIVA:  state_d = status.span_zero ? ST_ACHK : ST_WAITA;
			ST_WAITA: if (!status.div_busy) state_d = ST_AQ;
			ST_AQ:    state_d = ST_ACHK;
			ST_ACHK:  state_d = status.a_zero ? ST_HB1 : ST_AB1;
			ST_AB1:   state_d = ST_AB2;
			ST_AB2:   state_d = ST_AB3;
			ST_AB3:   state_d = ST_AW;
			ST_AW:    if (!status.cordic_busy) state_d = ST_KDIV;
			ST_KDIV:  state_d = ST_KW;
			ST_KW:    if (!status.div_busy) state_d = ST_KQ;
			ST_KQ:    state_d = ST_H1;
			ST_H1:    state_d = ST_H2;
			ST_H2:    state_d = ST_H3;
			ST_H3:    state_d = ST_H4;
			ST_H4:    state_d = ST_H5;
			ST_H5:    state_d = ST_H6;
			ST_H6:    state_d = ST_H7;
			ST_H7:    state_d = ST_H8;
			ST_H8:    state_d = ST_HB1;
			ST_HB1:   state_d = ST_HB2;
			ST_HB2:   state_d = ST_HB3;
			ST_HB3:   state_d = ST_HW;
			ST_HW:    if (!status.cordic_busy) state_d = ST_O1;
			ST_O1:    state_d = ST_O2;
			ST_O2:    state_d = ST_O3;
			ST_O3:    state_d = ST_O4;
			ST_O4:    state_d = ST_O5;
			ST_O5:    state_d = ST_O6;
			ST_O6:    state_d = ST_POST;
			// hold until the previous pose item is taken
			ST_POST:  if (!status.out_busy) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		cmd          = C_NOP;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				cmd          = sample_valid ? C_LOAD : C_NOP;
			end
			ST_ML:   cmd = C_ML;
			ST_MR:   cmd = C_MR;
			ST_MS:   cmd = C_MS;
			ST_DIVA: cmd = C_DIVA;
			ST_AQ:   cmd = C_AQ;
			ST_ACHK: cmd = status.a_zero ? C_STRAIGHT : C_NOP;
			ST_AB1:  cmd = C_B1A;
			ST_AB2:  cmd = C_B2;
			ST_AB3:  cmd = C_B3;
			ST_KDIV: cmd = C_KDIV;
			ST_KQ:   cmd = C_KQ;
			ST_H1:   cmd = C_H1;
			ST_H2:   cmd = C_H2;
			ST_H3:   cmd = C_H3;
			ST_H4:   cmd = C_H4;
			ST_H5:   cmd = C_H5;
			ST_H6:   cmd = C_H6;
			ST_H7:   cmd = C_H7;
			ST_H8:   cmd = C_H8;
			ST_HB1:  cmd = C_B1H;
			ST_HB2:  cmd = C_B2;
			ST_HB3:  cmd = C_B3;
			ST_O1:   cmd = C_O1;
			ST_O2:   cmd = C_O2;
			ST_O3:   cmd = C_O3;
			ST_O4:   cmd = C_O4;
			ST_O5:   cmd = C_O5;
			ST_O6:   cmd = C_O6;
			ST_POST: cmd = status.out_busy ? C_NOP : C_POST;
			default: cmd = C_NOP;
		endcase
	end

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AQ || state_q == ST_KQ) |-> !status.div_busy)
		else $error("quotient taken while divider busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == C_POST) |-> !status.out_busy)
		else $error("pose item overwritten before it was taken");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("second item accepted while one is in work");
endmodule

>>> tb/three_wheel_odometry_core_tb.sv
// Self-checking testbench for the three-wheel odometry core with a built-in pose predictor.
module three_wheel_odometry_core_tb;
	import odo_pkg::*;

	localparam int ANG_FB = 24;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 300;
	localparam longint CORDIC_X0 = 652032874;
	localparam longint ARCTAN_STEP [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	logic clk;
	logic arst_n;
	logic cfg_wen;
	reg_idx_t cfg_index;
	logic [23:0] cfg_data;
	logic sample_valid;
	logic sample_ready;
	sample_t sample;
	logic pose_valid;
	logic pose_ready;
	pose_t pose;

	three_wheel_odometry_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.pose_valid(pose_valid),
		.pose_ready(pose_ready),
		.pose(pose)
	);

	// predictor copy of the registers and the pose state
	longint tick_scale_q, left_off_q, right_off_q, rear_off_q;
	logic signed [31:0] prev_left = '0;
	logic signed [31:0] prev_right = '0;
	logic signed [31:0] prev_rear = '0;
	longint pose_x_acc = 0;
	longint pose_y_acc = 0;
	longint heading_acc = 0;

	sample_t pending_samples[$];
	pose_t expected_poses[$];
	int mismatches = 0;
	int cycle_count = 0;
	logic gap_free;
	logic stall_free;
	logic signed [31:0] walk_pos [3];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic longint round_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// radians with fb fraction bits to binary angle (turns * 2^32)
	function automatic logic [31:0] angle_to_turns(input longint ang, input int fb);
		logic neg;
		logic [63:0] mag, inv, prod;
		logic [31:0] t;
		neg = ang < 0;
		mag = neg ? 64'd0 - 64'(ang) : 64'(ang);
		inv = (INV_PI_Q63 + (64'd1 << (fb - 1))) >> fb;
		prod = mag * inv;
		t = prod[63:32];
		return neg ? 32'd0 - t : t;
	endfunction

	function automatic void cordic_sin_cos(input logic [31:0] t, output longint c,
			output longint sn);
		logic [31:0] u;
		logic flip;
		longint x, y, z, nx;
		u = t + 32'h4000_0000;
		flip = u[31];
		if (flip)
			t = t + 32'h8000_0000;
		z = longint'(signed'(t));
		x = CORDIC_X0;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ARCTAN_STEP[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ARCTAN_STEP[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function automatic longint wheel_inches(input logic signed [31:0] p,
			input logic signed [31:0] last);
		longint d;
		d = longint'(p) - longint'(last);
		return clamp32(round_shift(d * tick_scale_q, 16));
	endfunction

	task automatic predict_pose(input sample_t s);
		longint dl, dr, ds, span, a, h, h2, c, sn, hc, hs, k, two_s, dx, dy;
		pose_t p;
		dl = wheel_inches(s.left_position, prev_left);
		dr = wheel_inches(s.right_position, prev_right);
		ds = wheel_inches(s.rear_position, prev_rear);
		prev_left = s.left_position;
		prev_right = s.right_position;
		prev_rear = s.rear_position;
		span = left_off_q + right_off_q;
		a = 0;
		if (span != 0)
			a = clamp32(((dl - dr) * (64'sd1 <<< ANG_FB)) / span);
		if (a != 0) begin
			cordic_sin_cos(angle_to_turns(a, ANG_FB + 1), hc, hs);
			k = (2 * hs * (64'sd1 <<< ANG_FB)) / a;
			two_s = 2 * hs;
			h = clamp32(round_shift(dr * k, 30) + round_shift(right_off_q * two_s, 30));
			h2 = clamp32(round_shift(ds * k, 30) + round_shift(rear_off_q * two_s, 30));
		end else begin
			h = dr;
			h2 = ds;
		end
		cordic_sin_cos(angle_to_turns(2 * heading_acc + a, ANG_FB + 1), c, sn);
		dx = round_shift(h * sn + h2 * c, 30);
		dy = round_shift(h * c - h2 * sn, 30);
		pose_x_acc = clamp32(pose_x_acc + dx);
		pose_y_acc = clamp32(pose_y_acc + dy);
		heading_acc = clamp32(heading_acc + a);
		p.pose_x = pose_x_acc[31:0];
		p.pose_y = pose_y_acc[31:0];
		p.pose_heading = heading_acc[31:0];
		expected_poses.push_back(p);
	endtask

	// sample driver
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		logic busy;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			gap_left <= 0;
		end else begin
			busy = sample_valid;
			if (sample_valid && sample_ready) begin
				predict_pose(sample);
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					sample <= pending_samples.pop_front();
					sample_valid <= 1'b1;
					gap_left <= gap_free ? 0 : $urandom_range(0, 11);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// pose monitor
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		if (!arst_n) begin
			pose_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (pose_valid && pose_ready) begin
				if (expected_poses.size() == 0) begin
					report("pose item with nothing expected");
				end else begin
					want = expected_poses.pop_front();
					if (pose.pose_x !== want.pose_x)
						report($sformatf("pose_x got %0d want %0d", pose.pose_x, want.pose_x));
					if (pose.pose_y !== want.pose_y)
						report($sformatf("pose_y got %0d want %0d", pose.pose_y, want.pose_y));
					if (pose.pose_heading !== want.pose_heading)
						report($sformatf("pose_heading got %0d want %0d",
							pose.pose_heading, want.pose_heading));
				end
				stall_left <= stall_free ? 0 : $urandom_range(0, 11);
				pose_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				pose_ready <= 1'b0;
			end else begin
				pose_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout with %0d pose items outstanding", expected_poses.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_TICK_SCALE:   tick_scale_q = longint'(v);
			REG_LEFT_OFFSET:  left_off_q = longint'(v);
			REG_RIGHT_OFFSET: right_off_q = longint'(v);
			REG_REAR_OFFSET:  rear_off_q = longint'(v);
			default: ;
		endcase
	endtask

	task automatic configure(input logic [23:0] ts, input logic [23:0] lo,
			input logic [23:0] ro, input logic [23:0] so);
		write_reg(REG_TICK_SCALE, ts);
		write_reg(REG_LEFT_OFFSET, lo);
		write_reg(REG_RIGHT_OFFSET, ro);
		write_reg(REG_REAR_OFFSET, so);
	endtask

	task automatic wait_idle();
		while (pending_samples.size() != 0 || sample_valid || expected_poses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_sample(input logic [31:0] l, input logic [31:0] r,
			input logic [31:0] s);
		sample_t item;
		item.left_position = l;
		item.right_position = r;
		item.rear_position = s;
		pending_samples.push_back(item);
		walk_pos[0] = l;
		walk_pos[1] = r;
		walk_pos[2] = s;
	endtask

	// mostly small encoder steps from the last sample, some wide jumps
	task automatic random_samples(input int n, input int step);
		logic [31:0] v [3];
		for (int i = 0; i < n; i++) begin
			gap_free = ($urandom_range(0, 15) == 0) ? ~gap_free : gap_free;
			stall_free = ($urandom_range(0, 15) == 0) ? ~stall_free : stall_free;
			for (int w = 0; w < 3; w++) begin
				case ($urandom_range(0, 9))
					0: v[w] = $urandom;
					1: v[w] = walk_pos[w];
					default: v[w] = walk_pos[w] + $urandom_range(0, 2 * step) - step;
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				v[1] = v[0] - walk_pos[0] + walk_pos[1];
			push_sample(v[0], v[1], v[2]);
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_TICK_SCALE;
		cfg_data = '0;
		gap_free = 1'b0;
		stall_free = 1'b0;
		tick_scale_q = longint'(TICK_SCALE_RST);
		left_off_q = longint'(LEFT_OFFSET_RST);
		right_off_q = longint'(RIGHT_OFFSET_RST);
		rear_off_q = longint'(REAR_OFFSET_RST);
		walk_pos[0] = '0;
		walk_pos[1] = '0;
		walk_pos[2] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: straight motion, single wheels, turns, extremes
		push_sample(32'd0, 32'd0, 32'd0);
		push_sample(32'd3600, 32'd3600, 32'd0);
		push_sample(32'd7200, 32'd3600, 32'd0);
		push_sample(32'd7200, 32'd9000, 32'd0);
		push_sample(32'd7200, 32'd9000, 32'd500);
		push_sample(32'd7201, 32'd9000, 32'd500);
		push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		push_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'hAAAA_AAAA);
		push_sample(32'h5555_5555, 32'h5555_5555, 32'h5555_5555);
		wait_idle();

		// widest scale and spacing: saturating distances and headings
		configure(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		random_samples(120, 100000);

		// zero wheel spacing: no heading change ever
		configure(24'h12_3456, 24'd0, 24'd0, 24'd0);
		push_sample(32'd100000, 32'd0, 32'd5000);
		push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		random_samples(120, 50000);

		// zero scale: every distance is zero
		configure(24'd0, 24'd1, 24'hFF_FFFF, 24'd7);
		random_samples(60, 1000000);

		configure(TICK_SCALE_RST, LEFT_OFFSET_RST, RIGHT_OFFSET_RST, REAR_OFFSET_RST);
		random_samples(200, 3000);

		for (int ph = 0; ph < 4; ph++) begin
			configure(24'($urandom),
				24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 20)),
				24'($urandom >> $urandom_range(8, 24)), 24'($urandom));
			random_samples(110, 1 << $urandom_range(4, 20));
		end

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
